@@ hdl/bounded_sequence_list_macros.svh @@
// assertion macros for the bounded sequence list
`ifndef BOUNDED_SEQUENCE_LIST_MACROS_SVH
`define BOUNDED_SEQUENCE_LIST_MACROS_SVH

`ifndef SYNTHESIS
`define BSL_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bounded_sequence_list assertion failed");
`define BSL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bounded_sequence_list assertion failed");
`else
`define BSL_ASSERT_SAME(label, clk, rst, ante, cons)
`define BSL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ hdl/bsl_pkg.sv @@
// shared types and codes of the bounded sequence list
`default_nettype none

package bsl_pkg;

  localparam logic [2:0] CMD_ADD_FRONT    = 3'd0;
  localparam logic [2:0] CMD_ADD_BACK     = 3'd1;
  localparam logic [2:0] CMD_INSERT       = 3'd2;
  localparam logic [2:0] CMD_REMOVE_FRONT = 3'd3;
  localparam logic [2:0] CMD_REMOVE_BACK  = 3'd4;
  localparam logic [2:0] CMD_LIST         = 3'd5;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;
  localparam logic [1:0] STATUS_RANGE = 2'd3;

  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_POP    = 2'd2;
  localparam logic [1:0] OP_ROTATE = 2'd3;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] value;
    logic [4:0]         position;
  } req_t;

  typedef struct packed {
    logic signed [31:0] word;
    logic [1:0]         status;
    logic               last;
    logic [4:0]         occupancy;
  } rsp_t;

  typedef struct packed {
    logic [1:0] op;
    logic       emit;
    logic       emit_head;
    logic [1:0] status;
    logic       last;
  } ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic single;
  } stat_t;

endpackage

`default_nettype wire

@@ hdl/bsl_ctrl.sv @@
// command sequencer of the bounded sequence list
`default_nettype none

`include "bounded_sequence_list_macros.svh"

module bsl_ctrl #(
  parameter int COUNT_BITS = 5
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire bsl_pkg::req_t         req,
  input  wire logic [COUNT_BITS-1:0] count,
  input  wire bsl_pkg::stat_t        stat,
  output bsl_pkg::ctl_t              ctl,
  output logic [COUNT_BITS-1:0]      ins_pos
);

  localparam int PW = (COUNT_BITS > 5) ? COUNT_BITS : 5;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LIST  = 2'd1;
  localparam logic [1:0] ST_RBACK = 2'd2;

  logic [1:0]            state, state_next;
  logic [COUNT_BITS-1:0] remaining, remaining_next;
  logic                  pos_bad;

  assign busy    = (state != ST_IDLE);
  assign pos_bad = PW'(req.position) > PW'(count);

  always_comb begin
    ctl            = '0;
    ins_pos        = '0;
    state_next     = state;
    remaining_next = remaining;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (req.cmd)
            bsl_pkg::CMD_ADD_FRONT, bsl_pkg::CMD_ADD_BACK, bsl_pkg::CMD_INSERT: begin
              ctl.emit = 1'b1;
              ctl.last = 1'b1;
              if (stat.full) begin
                ctl.status = bsl_pkg::STATUS_FULL;
              end else if (req.cmd == bsl_pkg::CMD_INSERT && pos_bad) begin
                ctl.status = bsl_pkg::STATUS_RANGE;
              end else begin
                ctl.op = bsl_pkg::OP_INSERT;
                if (req.cmd == bsl_pkg::CMD_ADD_BACK) begin
                  ins_pos = count;
                end else if (req.cmd == bsl_pkg::CMD_INSERT) begin
                  ins_pos = COUNT_BITS'(req.position);
                end
              end
            end
            bsl_pkg::CMD_REMOVE_FRONT: begin
              ctl.emit = 1'b1;
              ctl.last = 1'b1;
              if (stat.empty) begin
                ctl.status = bsl_pkg::STATUS_EMPTY;
              end else begin
                ctl.op        = bsl_pkg::OP_POP;
                ctl.emit_head = 1'b1;
              end
            end
            bsl_pkg::CMD_REMOVE_BACK: begin
              if (stat.empty) begin
                ctl.emit   = 1'b1;
                ctl.last   = 1'b1;
                ctl.status = bsl_pkg::STATUS_EMPTY;
              end else if (stat.single) begin
                ctl.emit      = 1'b1;
                ctl.last      = 1'b1;
                ctl.op        = bsl_pkg::OP_POP;
                ctl.emit_head = 1'b1;
              end else begin
                // rotate the back word to the front, then pop it
                ctl.op         = bsl_pkg::OP_ROTATE;
                remaining_next = count - COUNT_BITS'(2);
                state_next     = ST_RBACK;
              end
            end
            bsl_pkg::CMD_LIST: begin
              ctl.emit = 1'b1;
              if (stat.empty) begin
                ctl.last   = 1'b1;
                ctl.status = bsl_pkg::STATUS_EMPTY;
              end else begin
                ctl.emit_head = 1'b1;
                ctl.op        = bsl_pkg::OP_ROTATE;
                ctl.last      = stat.single;
                if (!stat.single) begin
                  remaining_next = count - COUNT_BITS'(1);
                  state_next     = ST_LIST;
                end
              end
            end
            default: begin
              ctl.emit = 1'b1;
              ctl.last = 1'b1;
            end
          endcase
        end
      end
      ST_LIST: begin
        ctl.emit       = 1'b1;
        ctl.emit_head  = 1'b1;
        ctl.op         = bsl_pkg::OP_ROTATE;
        ctl.last       = (remaining == COUNT_BITS'(1));
        remaining_next = remaining - COUNT_BITS'(1);
        if (ctl.last) begin
          state_next = ST_IDLE;
        end
      end
      ST_RBACK: begin
        if (remaining == '0) begin
          ctl.emit      = 1'b1;
          ctl.emit_head = 1'b1;
          ctl.last      = 1'b1;
          ctl.op        = bsl_pkg::OP_POP;
          state_next    = ST_IDLE;
        end else begin
          ctl.op         = bsl_pkg::OP_ROTATE;
          remaining_next = remaining - COUNT_BITS'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      remaining <= '0;
    end else begin
      state     <= state_next;
      remaining <= remaining_next;
    end
  end

  `BSL_ASSERT_SAME(a_list_emits, clk, rst, state == ST_LIST, ctl.emit && ctl.emit_head)
  `BSL_ASSERT_SAME(a_remaining_in_range, clk, rst, state != ST_IDLE, remaining < count)
  `BSL_ASSERT_SAME(a_no_insert_full, clk, rst, ctl.op == bsl_pkg::OP_INSERT, !stat.full)
  `BSL_ASSERT_SAME(a_no_pop_empty, clk, rst, ctl.op == bsl_pkg::OP_POP, !stat.empty)
  `BSL_ASSERT_NEXT(a_last_frees, clk, rst, ctl.emit && ctl.last, state == ST_IDLE)

endmodule

`default_nettype wire

@@ hdl/bsl_dpath.sv @@
// cell chain, word count and result register of the bounded sequence list
`default_nettype none

module bsl_dpath #(
  parameter int CAPACITY   = 16,
  parameter int WORD_BITS  = 32,
  parameter int COUNT_BITS = 5
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire bsl_pkg::ctl_t         ctl,
  input  wire logic signed [31:0]    value,
  input  wire logic [COUNT_BITS-1:0] ins_pos,
  output logic [COUNT_BITS-1:0]      count,
  output bsl_pkg::stat_t             stat,
  output logic                       valid,
  output bsl_pkg::rsp_t              rsp
);

  logic [WORD_BITS-1:0]  cells  [CAPACITY];
  logic [WORD_BITS-1:0]  up_nb  [CAPACITY];
  logic [WORD_BITS-1:0]  dn_nb  [CAPACITY];
  logic [COUNT_BITS-1:0] count_next;
  logic [COUNT_BITS-1:0] last_idx;
  logic signed [63:0]    value_ext;
  logic signed [63:0]    head_ext;
  logic [WORD_BITS-1:0]  value_fit;

  assign value_ext = 64'(value);
  assign value_fit = value_ext[WORD_BITS-1:0];
  assign head_ext  = 64'(signed'(cells[0]));
  assign last_idx  = count - COUNT_BITS'(1);

  assign stat.empty  = (count == '0);
  assign stat.full   = (count == COUNT_BITS'(CAPACITY));
  assign stat.single = (count == COUNT_BITS'(1));

  for (genvar g = 0; g < CAPACITY; g++) begin : g_nb
    if (g == CAPACITY - 1) begin : g_top
      assign up_nb[g] = cells[g];
    end else begin : g_mid
      assign up_nb[g] = cells[g+1];
    end
    if (g == 0) begin : g_bot
      assign dn_nb[g] = cells[g];
    end else begin : g_rest
      assign dn_nb[g] = cells[g-1];
    end
  end

  always_comb begin
    case (ctl.op)
      bsl_pkg::OP_INSERT: count_next = count + COUNT_BITS'(1);
      bsl_pkg::OP_POP:    count_next = count - COUNT_BITS'(1);
      default:            count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      case (ctl.op)
        bsl_pkg::OP_INSERT: begin
          if (COUNT_BITS'(i) == ins_pos) begin
            cells[i] <= value_fit;
          end else if (COUNT_BITS'(i) > ins_pos) begin
            cells[i] <= dn_nb[i];
          end
        end
        bsl_pkg::OP_POP: begin
          cells[i] <= up_nb[i];
        end
        bsl_pkg::OP_ROTATE: begin
          if (COUNT_BITS'(i) == last_idx) begin
            cells[i] <= cells[0];
          end else begin
            cells[i] <= up_nb[i];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      valid <= 1'b0;
    end else begin
      count <= count_next;
      valid <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    rsp.word      <= ctl.emit_head ? head_ext[31:0] : 32'sd0;
    rsp.status    <= ctl.status;
    rsp.last      <= ctl.last;
    rsp.occupancy <= 5'(count_next);
  end

endmodule

`default_nettype wire

@@ hdl/bounded_sequence_list.sv @@
// bounded sequence list: ordered deque of signed words with positional insert
//
// A command word is taken at a rising edge with start high and busy low. Its
// cmd field adds at the front or back, inserts at a position, removes the
// front or back word, or lists all words front to back.
// Results come one per cycle on rsp, marked by valid for a single cycle; the
// receiver cannot hold them off, and rsp.last marks the final one of a command.
// Add, insert and remove front: one result the cycle after acceptance.
// Remove back: the held words are rotated one step per cycle until the back
// word sits at the front, then it is popped and shown as the result; busy
// drops in the cycle the result is shown.
// List: count results on consecutive cycles, starting the cycle after
// acceptance; the rotation through the cell chain restores the order.
// Errors (full, empty, position past the count) give one result and leave the
// list unchanged. busy is high while a list or remove back is in progress.
// Reset empties the list; held words are not cleared.
`default_nettype none

module bounded_sequence_list #(
  parameter int CAPACITY  = 16,
  parameter int WORD_BITS = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire bsl_pkg::req_t req,
  output logic               valid,
  output bsl_pkg::rsp_t      rsp
);

  localparam int COUNT_BITS = $clog2(CAPACITY + 1);

  bsl_pkg::ctl_t         ctl;
  bsl_pkg::stat_t        stat;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] ins_pos;

  bsl_ctrl #(
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .req     (req),
    .count   (count),
    .stat    (stat),
    .ctl     (ctl),
    .ins_pos (ins_pos)
  );

  bsl_dpath #(
    .CAPACITY   (CAPACITY),
    .WORD_BITS  (WORD_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .value   (req.value),
    .ins_pos (ins_pos),
    .count   (count),
    .stat    (stat),
    .valid   (valid),
    .rsp     (rsp)
  );

endmodule

`default_nettype wire

@@ sim/tb_bounded_sequence_list.sv @@
// bounded sequence list testbench: directed and random commands checked against a deque model
`timescale 1ns / 100ps

module tb_bounded_sequence_list;

  localparam int CAPACITY    = 16;
  localparam int CLK_PERIOD  = 4;
  localparam int RESET_TICKS = 10;
  localparam int RANDOM_CMDS = 250;
  localparam int TAIL_TICKS  = 40;
  localparam int TIMEOUT_NS  = 2000000;

  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  localparam int PHASE_FILL  = 0;
  localparam int PHASE_DRAIN = 1;
  localparam int PHASE_MIXED = 2;

  typedef struct packed {
    bit            wait_idle;
    bsl_pkg::req_t cmd_word;
  } backlog_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  bsl_pkg::req_t req = '0;
  logic busy;
  logic valid;
  bsl_pkg::rsp_t rsp;

  backlog_t      cmd_backlog[$];
  bsl_pkg::rsp_t due_results[$];
  logic signed [31:0] held_words[$];

  int n_total = 0;
  int n_issued = 0;
  int n_taken = 0;
  int fail_count = 0;
  int gap_left = 0;
  int burst_left = 0;
  int shadow_count = 0;
  backlog_t next_cmd;
  bsl_pkg::rsp_t due;

  bounded_sequence_list #(
    .CAPACITY (CAPACITY),
    .WORD_BITS(32)
  ) u_top (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .valid(valid),
    .rsp  (rsp)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // deque model: works out every result a command word causes
  task automatic apply_command(input bsl_pkg::req_t cw);
    bsl_pkg::rsp_t e;
    int i;
    e = '0;
    e.last = 1'b1;
    case (cw.cmd)
      bsl_pkg::CMD_ADD_FRONT: begin
        if (held_words.size() >= CAPACITY) e.status = bsl_pkg::STATUS_FULL;
        else held_words.push_front(cw.value);
      end
      bsl_pkg::CMD_ADD_BACK: begin
        if (held_words.size() >= CAPACITY) e.status = bsl_pkg::STATUS_FULL;
        else held_words.push_back(cw.value);
      end
      bsl_pkg::CMD_INSERT: begin
        if (held_words.size() >= CAPACITY) e.status = bsl_pkg::STATUS_FULL;
        else if (int'(cw.position) > held_words.size()) e.status = bsl_pkg::STATUS_RANGE;
        else held_words.insert(int'(cw.position), cw.value);
      end
      bsl_pkg::CMD_REMOVE_FRONT: begin
        if (held_words.size() == 0) e.status = bsl_pkg::STATUS_EMPTY;
        else e.word = held_words.pop_front();
      end
      bsl_pkg::CMD_REMOVE_BACK: begin
        if (held_words.size() == 0) e.status = bsl_pkg::STATUS_EMPTY;
        else e.word = held_words.pop_back();
      end
      bsl_pkg::CMD_LIST: begin
        if (held_words.size() == 0) e.status = bsl_pkg::STATUS_EMPTY;
      end
      default: begin
      end
    endcase
    e.occupancy = 5'(held_words.size());
    if (cw.cmd == bsl_pkg::CMD_LIST && held_words.size() != 0) begin
      for (i = 0; i < held_words.size(); i++) begin
        e.word = held_words[i];
        e.last = (i == held_words.size() - 1);
        due_results.push_back(e);
      end
    end else begin
      due_results.push_back(e);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (valid) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, expected none", $time);
          $display("%0t:   got word %0d status %0d last %0d occupancy %0d",
                   $time, rsp.word, rsp.status, rsp.last, rsp.occupancy);
          fail_count++;
        end else begin
          due = due_results.pop_front();
          if (rsp.word !== due.word || rsp.status !== due.status ||
              rsp.last !== due.last || rsp.occupancy !== due.occupancy) begin
            $display("%0t: mismatch, expected word %0d status %0d last %0d occupancy %0d",
                     $time, due.word, due.status, due.last, due.occupancy);
            $display("%0t:           got word %0d status %0d last %0d occupancy %0d",
                     $time, rsp.word, rsp.status, rsp.last, rsp.occupancy);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        apply_command(req);
        n_taken++;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || n_taken == n_issued) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (cmd_backlog.size() != 0 &&
                   !(cmd_backlog[0].wait_idle && due_results.size() != 0)) begin
        next_cmd = cmd_backlog.pop_front();
        req <= next_cmd.cmd_word;
        start <= 1'b1;
        n_issued++;
        if (burst_left > 0) begin
          burst_left--;
          gap_left = 0;
        end else begin
          if ($urandom_range(0, 99) < 4) burst_left = $urandom_range(15, 30);
          gap_left = pick_gap();
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic queue_cmd(input logic [2:0] cmd, input logic [31:0] value,
                           input logic [4:0] position, input bit wait_idle);
    backlog_t b;
    b.wait_idle = wait_idle;
    b.cmd_word.cmd = cmd;
    b.cmd_word.value = value;
    b.cmd_word.position = position;
    cmd_backlog.push_back(b);
    case (cmd)
      bsl_pkg::CMD_ADD_FRONT, bsl_pkg::CMD_ADD_BACK: begin
        if (shadow_count < CAPACITY) shadow_count++;
      end
      bsl_pkg::CMD_INSERT: begin
        if (shadow_count < CAPACITY && int'(position) <= shadow_count) shadow_count++;
      end
      bsl_pkg::CMD_REMOVE_FRONT, bsl_pkg::CMD_REMOVE_BACK: begin
        if (shadow_count > 0) shadow_count--;
      end
      default: begin
      end
    endcase
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 19))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_cmd(input int phase);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
    case (phase)
      PHASE_FILL: begin
        if (r < 35) return bsl_pkg::CMD_ADD_FRONT;
        if (r < 60) return bsl_pkg::CMD_ADD_BACK;
        if (r < 88) return bsl_pkg::CMD_INSERT;
        if (r < 94) return bsl_pkg::CMD_LIST;
        return $urandom_range(0, 1) ? bsl_pkg::CMD_REMOVE_FRONT : bsl_pkg::CMD_REMOVE_BACK;
      end
      PHASE_DRAIN: begin
        if (r < 45) return bsl_pkg::CMD_REMOVE_FRONT;
        if (r < 78) return bsl_pkg::CMD_REMOVE_BACK;
        if (r < 90) return bsl_pkg::CMD_LIST;
        return bsl_pkg::CMD_INSERT;
      end
      default: return 3'($urandom_range(0, 5));
    endcase
  endfunction

  initial begin
    int n_random;
    int phase;
    int phase_len;
    int k;
    logic [2:0] cmd;
    logic [4:0] pos;

    queue_cmd(bsl_pkg::CMD_LIST, 32'd0, 5'd0, 1'b0);
    queue_cmd(bsl_pkg::CMD_REMOVE_FRONT, 32'd0, 5'd0, 1'b0);
    queue_cmd(bsl_pkg::CMD_REMOVE_BACK, 32'd0, 5'd0, 1'b0);
    queue_cmd(bsl_pkg::CMD_INSERT, 32'd5, 5'd1, 1'b0);
    queue_cmd(bsl_pkg::CMD_INSERT, 32'h7fff_ffff, 5'd0, 1'b0);
    queue_cmd(bsl_pkg::CMD_REMOVE_FRONT, 32'd0, 5'd0, 1'b0);
    queue_cmd(bsl_pkg::CMD_INSERT, 32'h8000_0000, 5'd0, 1'b0);
    queue_cmd(bsl_pkg::CMD_REMOVE_BACK, 32'd0, 5'd0, 1'b0);
    queue_cmd(bsl_pkg::CMD_ADD_BACK, 32'hffff_ffff, 5'd31, 1'b0);
    queue_cmd(bsl_pkg::CMD_ADD_FRONT, 32'h8000_0000, 5'd0, 1'b0);
    queue_cmd(bsl_pkg::CMD_ADD_BACK, 32'h7fff_ffff, 5'd0, 1'b0);
    queue_cmd(bsl_pkg::CMD_INSERT, 32'h1234_5678, 5'd1, 1'b0);
    queue_cmd(bsl_pkg::CMD_INSERT, 32'd0, 5'd4, 1'b0);
    queue_cmd(bsl_pkg::CMD_INSERT, 32'hdead_beef, 5'd6, 1'b0);
    queue_cmd(bsl_pkg::CMD_INSERT, 32'hdead_beef, 5'd31, 1'b0);
    queue_cmd(bsl_pkg::CMD_LIST, 32'hffff_ffff, 5'd31, 1'b0);
    queue_cmd(CMD_SPARE_A, 32'hffff_ffff, 5'd31, 1'b0);
    queue_cmd(CMD_SPARE_B, 32'h5555_aaaa, 5'd21, 1'b0);
    queue_cmd(bsl_pkg::CMD_REMOVE_BACK, 32'd0, 5'd0, 1'b0);
    queue_cmd(bsl_pkg::CMD_REMOVE_FRONT, 32'd0, 5'd0, 1'b0);
    queue_cmd(bsl_pkg::CMD_LIST, 32'd0, 5'd0, 1'b1);

    // random phases that fill up, drain out or mix, so full and empty are hit often
    n_random = 0;
    while (n_random < RANDOM_CMDS) begin
      phase = $urandom_range(0, 2);
      phase_len = $urandom_range(10, 40);
      for (k = 0; k < phase_len && n_random < RANDOM_CMDS; k++) begin
        cmd = pick_cmd(phase);
        if ($urandom_range(0, 99) < 80) pos = 5'($urandom_range(0, shadow_count));
        else pos = 5'($urandom_range(0, 31));
        queue_cmd(cmd, pick_value(), pos, k == 0 && $urandom_range(0, 99) < 30);
        n_random++;
      end
    end
    n_total = cmd_backlog.size();

    repeat (RESET_TICKS) @(negedge clk);
    rst <= 1'b0;

    while (n_taken < n_total) @(negedge clk);
    while (due_results.size() != 0) @(negedge clk);
    repeat (TAIL_TICKS) @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout", $time);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ bounded_sequence_list.f @@
+incdir+hdl
hdl/bsl_pkg.sv
hdl/bsl_ctrl.sv
hdl/bsl_dpath.sv
hdl/bounded_sequence_list.sv
sim/tb_bounded_sequence_list.sv
